[design/let_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// let_pkg: shared types and constants for the line envelope tree
// Opcodes, widths and the front-to-back command record.
// ----------------------------------------------------------------------------
package let_pkg;
   localparam int XBitsDefault = 10;
   localparam int CoefW        = 33;
   localparam int ProdW        = 66;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam logic [0:0] CSR_MIN_MODE   = 1'b0;
   localparam logic [0:0] CSR_DOMAIN_LOW = 1'b1;

   // command record handed from front to back
   typedef struct packed {
      logic                    opcode;
      logic signed [CoefW-1:0] slope;
      logic signed [CoefW-1:0] icpt;
      logic signed [32:0]      x;
      logic [31:0]             off;
      logic                    oor;
   } cmd_type;
endpackage

[design/let_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// let_front: accepts items, applies mode negation and range check
// Writes a command record into a small queue for the back end.
// ----------------------------------------------------------------------------
module let_front import let_pkg::*; #(
   parameter int XBits = XBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_opcode,
   input  logic signed [31:0] req_line_slope,
   input  logic signed [31:0] req_line_intercept,
   input  logic signed [31:0] req_query_x,
   input  logic               min_mode,
   input  logic signed [31:0] domain_low,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output cmd_type            head
);
   localparam int Depth = 2;
   cmd_type          q_ff [Depth];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   cmd_type          c;
   logic signed [33:0] off;

   // classify the item
   always_comb begin
      off = 34'(req_query_x) - 34'(domain_low);
      c.opcode = req_opcode;
      c.slope  = min_mode ? -33'(req_line_slope) : 33'(req_line_slope);
      c.icpt   = min_mode ? -33'(req_line_intercept) : 33'(req_line_intercept);
      c.x      = 33'(req_query_x);
      c.off    = off[31:0];
      c.oor    = off[33] || (off[32:0] >= 33'(34'd1 << XBits));
   end

   always_comb begin
      wp_in  = wp_ff ^ req_valid;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + 2'(req_valid) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (req_valid) q_ff[wp_ff] <= c;
   end

   assign full      = (cnt_ff == 2'(Depth));
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = q_ff[rp_ff];
endmodule

[design/let_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// let_back: walks the tree level by level for inserts and queries
// Per level: read node, multiply, compare, update. Node valid marks live in
// a memory that a clearing pass zeroes after reset.
// ----------------------------------------------------------------------------
module let_back import let_pkg::*; #(
   parameter int XBits = XBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               not_empty,
   input  cmd_type            head,
   input  logic               min_mode,
   input  logic signed [31:0] domain_low,
   output logic               pop,
   output logic               idle,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_best_value,
   output logic               rsp_empty_res,
   output logic               rsp_out_of_range
);
   localparam int NodeW = XBits + 1;
   localparam int Nodes = 1 << NodeW;
   localparam int SpanW = XBits;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_MULA = 3'd2;
   localparam logic [2:0] ST_MULB = 3'd3;
   localparam logic [2:0] ST_DEC  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;
   localparam logic [2:0] ST_CLR  = 3'd6;

   logic [CoefW-1:0] ms_mem [Nodes];
   logic [CoefW-1:0] mc_mem [Nodes];
   logic             vld_mem [Nodes];
   logic             root_vld_ff;

   logic [2:0]  st_ff, st_in;
   logic [NodeW-1:0] clr_ff, clr_in;
   cmd_type     cmd_ff;
   logic [NodeW-1:0] idx_ff, idx_in;
   logic [SpanW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [CoefW-1:0] s_ff, s_in, c_ff, c_in;
   logic signed [CoefW-1:0] ns_ff, nc_ff;
   logic        nv_ff;
   logic [1:0]  k_ff, k_in;
   logic signed [ProdW-1:0] pn_ff [3];
   logic signed [ProdW-1:0] pc_ff [3];
   logic signed [ProdW-1:0] best_ff, best_in;
   logic        found_ff, found_in;
   logic        wr_en;
   logic signed [CoefW-1:0] wr_s, wr_c;
   logic [SpanW-1:0] mid;
   logic signed [33:0] xk;
   logic signed [ProdW-1:0] vn, vc;
   logic wl, wm, wr, wl2, last;
   logic signed [63:0] res;

   assign mid  = SpanW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign last = (lo_ff == hi_ff);

   // x point for multiply pass k: query x, or lo/mid/hi for inserts
   always_comb begin
      xk = 34'(cmd_ff.x);
      if (cmd_ff.opcode == OP_INSERT) begin
         case (k_ff)
            2'd0:    xk = 34'(domain_low) + 34'(lo_ff);
            2'd1:    xk = 34'(domain_low) + 34'(mid);
            default: xk = 34'(domain_low) + 34'(hi_ff);
         endcase
      end
      vn = ProdW'(ns_ff) * ProdW'(xk);
      vc = ProdW'(s_ff)  * ProdW'(xk);
   end

   always_comb begin
      wl  = (pn_ff[0] + ProdW'(nc_ff)) < (pc_ff[0] + ProdW'(c_ff));
      wm  = (pn_ff[1] + ProdW'(nc_ff)) < (pc_ff[1] + ProdW'(c_ff));
      wr  = (pn_ff[2] + ProdW'(nc_ff)) < (pc_ff[2] + ProdW'(c_ff));
      wl2 = wm ? !wl : wl;
   end

   // sequencer
   always_comb begin
      st_in = st_ff; idx_in = idx_ff; lo_in = lo_ff; hi_in = hi_ff;
      s_in = s_ff; c_in = c_ff; k_in = k_ff; clr_in = clr_ff;
      best_in = best_ff; found_in = found_ff;
      wr_en = 1'b0; wr_s = s_ff; wr_c = c_ff; pop = 1'b0;
      unique case (st_ff)
         ST_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (not_empty) begin
               pop = 1'b1;
               idx_in = NodeW'(1); lo_in = '0; hi_in = '1;
               s_in = head.slope; c_in = head.icpt;
               found_in = 1'b0; best_in = '0;
               st_in = (head.opcode == OP_QUERY && head.oor) ? ST_DONE : ST_READ;
            end
         end
         ST_READ: begin
            k_in  = 2'd0;
            st_in = ST_MULA;
         end
         ST_MULA: begin
            if (cmd_ff.opcode == OP_QUERY) begin
               st_in = ST_DEC;
            end else if (!nv_ff) begin
               wr_en = 1'b1;
               st_in = ST_DONE;
            end else begin
               k_in  = k_ff + 2'd1;
               st_in = (k_ff == 2'd2) ? ST_DEC : ST_MULA;
            end
         end
         ST_MULB: st_in = ST_DEC;
         ST_DEC: begin
            if (cmd_ff.opcode == OP_QUERY) begin
               if (nv_ff) begin
                  if (!found_ff || pn_ff[0] + ProdW'(nc_ff) > best_ff)
                     best_in = pn_ff[0] + ProdW'(nc_ff);
                  found_in = 1'b1;
               end
               if (last) st_in = ST_DONE;
               else begin
                  st_in = ST_READ;
                  if (cmd_ff.off[SpanW-1:0] <= mid) begin
                     idx_in = {idx_ff[NodeW-2:0], 1'b0}; hi_in = mid;
                  end else begin
                     idx_in = {idx_ff[NodeW-2:0], 1'b1}; lo_in = mid + 1'b1;
                  end
               end
            end else begin
               if (!wl && !wr) st_in = ST_DONE;
               else if (wl && wr) begin
                  wr_en = 1'b1; st_in = ST_DONE;
               end else begin
                  if (wm) begin
                     wr_en = 1'b1; s_in = ns_ff; c_in = nc_ff;
                  end
                  if (last) st_in = ST_DONE;
                  else begin
                     st_in = ST_READ;
                     if (wl2) begin
                        idx_in = {idx_ff[NodeW-2:0], 1'b0}; hi_in = mid;
                     end else begin
                        idx_in = {idx_ff[NodeW-2:0], 1'b1}; lo_in = mid + 1'b1;
                     end
                  end
               end
            end
         end
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_CLR;
         clr_ff      <= '0;
         root_vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
         if (wr_en && idx_ff == NodeW'(1)) root_vld_ff <= 1'b1;
      end
      idx_ff <= idx_in; lo_ff <= lo_in; hi_ff <= hi_in;
      s_ff <= s_in; c_ff <= c_in; k_ff <= k_in;
      best_ff <= best_in; found_ff <= found_in;
      if (pop) cmd_ff <= head;
      // node memory: one read, one write port
      if (wr_en) begin
         ms_mem[idx_ff] <= wr_s;
         mc_mem[idx_ff] <= wr_c;
      end
      // valid marks: cleared one entry per cycle after reset, then set on write
      if (st_ff == ST_CLR) vld_mem[clr_ff] <= 1'b0;
      else if (wr_en) vld_mem[idx_ff] <= 1'b1;
      if (st_ff == ST_READ) begin
         ns_ff <= ms_mem[idx_ff];
         nc_ff <= mc_mem[idx_ff];
         nv_ff <= vld_mem[idx_ff];
      end
      if (st_ff == ST_MULA) begin
         pn_ff[k_ff] <= vn;
         pc_ff[k_ff] <= vc;
      end
   end

   // result
   assign res = min_mode ? -best_ff[63:0] : best_ff[63:0];
   assign idle             = (st_ff == ST_IDLE) && !not_empty;
   assign rsp_valid        = (st_ff == ST_DONE) && (cmd_ff.opcode == OP_QUERY);
   assign rsp_best_value   = (found_ff && !cmd_ff.oor) ? res : 64'sd0;
   assign rsp_empty_res    = !root_vld_ff;
   assign rsp_out_of_range = cmd_ff.oor;
endmodule

[design/line_envelope_tree_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_envelope_tree_core: Li Chao tree of lines, max or min envelope
// Front classifies items, a two-entry queue feeds the tree walker.
// ----------------------------------------------------------------------------
// channel  | handshake              | payload
// req_     | start & !busy          | opcode, line_slope, line_intercept, query_x
// rsp_     | rsp_valid (one cycle)  | best_value, empty_res, out_of_range
// csr_     | csr_valid & csr_ready  | csr_index, csr_wdata
//
// An item walks at most XBits+1 levels; a query level reads the node,
// does one multiply pass and decides, an insert level reads, does three
// multiply passes and decides, set by the single node memory port and the
// one multiplier pair. Reset starts a clearing pass over the node valid
// marks, one entry a cycle, that ends before the first item is taken up.
// The receiver cannot stall; busy holds while the queue is full.
module line_envelope_tree_core import let_pkg::*; #(
   parameter int XBits = XBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic signed [31:0] req_line_slope,
   input  logic signed [31:0] req_line_intercept,
   input  logic signed [31:0] req_query_x,
   output logic               rsp_valid,
   output logic signed [63:0] rsp_best_value,
   output logic               rsp_empty_res,
   output logic               rsp_out_of_range,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   logic               min_mode_ff;
   logic signed [31:0] domain_low_ff;
   logic full, not_empty, pop, idle;
   cmd_type head;

   assign busy      = full;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_mode_ff   <= 1'b0;
         domain_low_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_MODE:   min_mode_ff   <= csr_wdata[0];
            CSR_DOMAIN_LOW: domain_low_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   let_front #(.XBits(XBits)) u_front (
      .clock, .reset,
      .req_valid(start && !busy),
      .req_opcode, .req_line_slope, .req_line_intercept, .req_query_x,
      .min_mode(min_mode_ff), .domain_low(domain_low_ff),
      .pop, .full, .not_empty, .head
   );

   let_back #(.XBits(XBits)) u_back (
      .clock, .reset, .not_empty, .head,
      .min_mode(min_mode_ff), .domain_low(domain_low_ff),
      .pop, .idle, .rsp_valid, .rsp_best_value, .rsp_empty_res, .rsp_out_of_range
   );

`ifndef ASSERT_OFF
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("pop from empty queue");
   a_rsp_not_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !idle) else $error("result while idle");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result longer than one cycle");
`endif
endmodule

[sim/line_envelope_tree_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_envelope_tree_core_tb: self-checking bench for the line envelope tree
// Drives inserts and queries in bursts, predicts every query answer with a
// local tree of lines, and checks each response in order. The mode and the
// domain are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module line_envelope_tree_core_tb;
   import let_pkg::*;

   localparam int  SpanBits   = 10;
   localparam int  Span       = 1 << SpanBits;
   localparam int  Slots      = 1 << (SpanBits + 1);
   localparam int  DrainWait  = 250;
   localparam int  StallLimit = 20000;

   typedef struct {
      logic               opcode;
      logic signed [31:0] slope;
      logic signed [31:0] icpt;
      logic signed [31:0] qx;
   } op_item_type;

   typedef struct {
      logic signed [63:0] best;
      logic               empty;
      logic               oor;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_opcode = OP_INSERT;
   logic signed [31:0] req_line_slope = '0;
   logic signed [31:0] req_line_intercept = '0;
   logic signed [31:0] req_query_x = '0;
   logic               rsp_valid;
   logic signed [63:0] rsp_best_value;
   logic               rsp_empty_res;
   logic               rsp_out_of_range;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [0:0]         csr_index = CSR_MIN_MODE;
   logic [31:0]        csr_wdata = '0;

   op_item_type pending_ops[$];
   answer_type  expected_answers[$];
   int       error_count = 0;
   int       quiet_cycles = 0;
   bit       gaps_enabled = 1'b1;
   int       burst_left = 0;
   int       gap_left = 0;

   // local copy of the tree and of the registers
   longint   tree_slope[Slots];
   longint   tree_icpt[Slots];
   bit       tree_valid[Slots];
   bit       mode_min = 1'b0;
   longint   dom_low = 0;

   line_envelope_tree_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_line_slope(req_line_slope),
      .req_line_intercept(req_line_intercept), .req_query_x(req_query_x),
      .rsp_valid(rsp_valid), .rsp_best_value(rsp_best_value),
      .rsp_empty_res(rsp_empty_res), .rsp_out_of_range(rsp_out_of_range),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // add one line to the tree (already negated in min mode)
   function automatic void tree_add_line(longint s, longint c);
      int unsigned idx, lo, hi, mid;
      longint      xl, xm, xr, ts, tc;
      bit          wl, wm, wr;
      idx = 1; lo = 0; hi = Span - 1;
      forever begin
         mid = (lo + hi) >> 1;
         xl = dom_low + lo; xm = dom_low + mid; xr = dom_low + hi;
         if (!tree_valid[idx]) begin
            tree_slope[idx] = s; tree_icpt[idx] = c; tree_valid[idx] = 1'b1;
            return;
         end
         wl = tree_slope[idx] * xl + tree_icpt[idx] < s * xl + c;
         wm = tree_slope[idx] * xm + tree_icpt[idx] < s * xm + c;
         wr = tree_slope[idx] * xr + tree_icpt[idx] < s * xr + c;
         if (!wl && !wr) return;
         if (wl && wr) begin
            tree_slope[idx] = s; tree_icpt[idx] = c;
            return;
         end
         if (wm) begin
            ts = tree_slope[idx]; tc = tree_icpt[idx];
            tree_slope[idx] = s; tree_icpt[idx] = c;
            s = ts; c = tc; wl = !wl;
         end
         if (lo == hi) return;
         if (wl) begin
            idx = 2 * idx; hi = mid;
         end else begin
            idx = 2 * idx + 1; lo = mid + 1;
         end
      end
   endfunction

   // best value over the root-to-leaf path of x
   function automatic answer_type tree_best_at(longint x);
      answer_type  a;
      longint      off, v, best;
      int unsigned idx, lo, hi, mid, o;
      bit          found;
      off = x - dom_low;
      a.oor = (off < 0 || off >= Span);
      found = 1'b0; best = 0;
      if (!a.oor) begin
         o = off; idx = 1; lo = 0; hi = Span - 1;
         forever begin
            mid = (lo + hi) >> 1;
            if (tree_valid[idx]) begin
               v = tree_slope[idx] * x + tree_icpt[idx];
               if (!found || v > best) best = v;
               found = 1'b1;
            end
            if (lo == hi) break;
            if (o <= mid) begin
               idx = 2 * idx; hi = mid;
            end else begin
               idx = 2 * idx + 1; lo = mid + 1;
            end
         end
         if (mode_min) best = -best;
      end
      if (!found) best = 0;
      a.best = best;
      a.empty = !tree_valid[1];
      return a;
   endfunction

   // work out the outcome of one accepted item
   function automatic void predict_item(op_item_type it);
      longint s, c;
      if (it.opcode == OP_INSERT) begin
         s = it.slope; c = it.icpt;
         if (mode_min) begin
            s = -s; c = -c;
         end
         tree_add_line(s, c);
      end else begin
         expected_answers = {expected_answers, tree_best_at(longint'(it.qx))};
      end
   endfunction

   // driver: bursts and gaps, one start assignment per edge
   always @(posedge clock) begin
      logic next_start;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_item(pending_ops.pop_front());
            if (burst_left > 0) burst_left--;
         end
         next_start = 1'b0;
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = gaps_enabled ? $urandom_range(0, 20) : 0;
         end
         if (gap_left > 0 && !(start && busy)) begin
            gap_left--;
         end else if (pending_ops.size() > 0) begin
            next_start = 1'b1;
            req_opcode <= pending_ops[0].opcode;
            req_line_slope <= pending_ops[0].slope;
            req_line_intercept <= pending_ops[0].icpt;
            req_query_x <= pending_ops[0].qx;
         end
         start <= next_start;
      end
   end

   // monitor: every strobe must match the oldest expected answer
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected response best=%0d", $time, rsp_best_value);
            error_count++;
         end else begin
            e = expected_answers.pop_front();
            if (rsp_best_value !== e.best) begin
               $display("%0t: best_value expected %0d got %0d", $time, e.best,
                        rsp_best_value);
               error_count++;
            end
            if (rsp_empty_res !== e.empty) begin
               $display("%0t: empty_res expected %0b got %0b", $time, e.empty,
                        rsp_empty_res);
               error_count++;
            end
            if (rsp_out_of_range !== e.oor) begin
               $display("%0t: out_of_range expected %0b got %0b", $time, e.oor,
                        rsp_out_of_range);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(logic [0:0] idx, logic [31:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_MIN_MODE) mode_min = data[0];
      else dom_low = longint'(signed'(data));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic push_op(logic op, logic signed [31:0] s, logic signed [31:0] c,
                          logic signed [31:0] x);
      op_item_type it;
      it.opcode = op; it.slope = s; it.icpt = c; it.qx = x;
      pending_ops = {pending_ops, it};
   endtask

   function automatic logic signed [31:0] pick_coef();
      case ($urandom_range(0, 5))
         0:       return $urandom;
         1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         2:       return $urandom_range(0, 2000000) - 1000000;
         default: return $urandom_range(0, 400) - 200;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_x();
      longint v;
      if ($urandom_range(0, 9) == 0) return $urandom;
      v = dom_low + $urandom_range(0, Span - 1);
      if (v > 64'sd2147483647) v = dom_low;
      return v[31:0];
   endfunction

   // wait until all queued items are done and the walker has gone quiet
   task automatic drain();
      while (pending_ops.size() > 0 || expected_answers.size() > 0)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic random_phase(int count);
      repeat (count) begin
         if ($urandom_range(0, 1)) push_op(OP_INSERT, pick_coef(), pick_coef(), $urandom);
         else push_op(OP_QUERY, $urandom, $urandom, pick_x());
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < Slots; i++) begin
         tree_valid[i] = 1'b0; tree_slope[i] = 0; tree_icpt[i] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty tree, domain edges, extreme coefficients, ties
      write_reg(CSR_MIN_MODE, 32'd0);
      write_reg(CSR_DOMAIN_LOW, 32'hffffff00);
      push_op(OP_QUERY, 32'sh7fffffff, 32'sh80000000, -32'sd256);
      push_op(OP_QUERY, 0, 0, -32'sd257);
      push_op(OP_QUERY, 0, 0, 32'sd768);
      push_op(OP_INSERT, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      push_op(OP_QUERY, 0, 0, -32'sd256);
      push_op(OP_INSERT, 32'sh80000000, 32'sh7fffffff, 0);
      push_op(OP_INSERT, 32'sh80000000, 32'sh7fffffff, 0);
      push_op(OP_INSERT, 0, 5, 0);
      push_op(OP_INSERT, 3, -7, 0);
      push_op(OP_INSERT, -3, 100, 0);
      push_op(OP_QUERY, 0, 0, -32'sd256);
      push_op(OP_QUERY, 0, 0, 32'sd767);
      push_op(OP_QUERY, 0, 0, 32'sd255);
      push_op(OP_QUERY, 0, 0, 32'sd256);
      push_op(OP_QUERY, 0, 0, 0);
      push_op(OP_QUERY, 0, 0, 32'sh7fffffff);
      push_op(OP_QUERY, 0, 0, 32'sh80000000);
      drain();

      // random phases across mode and domain settings
      random_phase(250);
      write_reg(CSR_MIN_MODE, 32'd1);
      write_reg(CSR_DOMAIN_LOW, 32'h80000000);
      gaps_enabled = 1'b0;
      random_phase(250);
      write_reg(CSR_MIN_MODE, 32'd0);
      write_reg(CSR_DOMAIN_LOW, 32'h7fffffff);
      gaps_enabled = 1'b1;
      random_phase(200);
      write_reg(CSR_MIN_MODE, 32'd1);
      write_reg(CSR_DOMAIN_LOW, 32'h7ffffc00);
      random_phase(250);
      write_reg(CSR_DOMAIN_LOW, 32'hfffffe00);
      gaps_enabled = 1'b0;
      random_phase(250);
      write_reg(CSR_MIN_MODE, 32'd0);
      write_reg(CSR_DOMAIN_LOW, $urandom);
      gaps_enabled = 1'b1;
      random_phase(430);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
